>>> hw/rtl/fqsr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FIFO queue with search and removal: shared package
// Request and response payload types, operation and status codes, defaults.
// ----------------------------------------------------------------------------
package fqsr_pkg;

    localparam int DEPTH_DEFAULT      = 16;
    localparam int ITEM_WIDTH_DEFAULT = 32;

    localparam int OPCODE_W     = 2;
    localparam int ITEM_VALUE_W = 32;
    localparam int STATUS_W     = 2;
    localparam int ITEM_OUT_W   = 32;
    localparam int POSITION_W   = 4;
    localparam int COUNT_W      = 5;

    typedef enum logic [OPCODE_W-1:0] {
        OP_PUSH   = 2'd0,
        OP_POP    = 2'd1,
        OP_FIND   = 2'd2,
        OP_REMOVE = 2'd3
    } op_t;

    localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_MISS = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

    typedef struct packed {
        logic [OPCODE_W-1:0]     opcode;
        logic [ITEM_VALUE_W-1:0] item_value;
    } fqsr_req_t;

    typedef struct packed {
        logic [STATUS_W-1:0]   status;
        logic [ITEM_OUT_W-1:0] item_out;
        logic [POSITION_W-1:0] position;
        logic [COUNT_W-1:0]    count;
    } fqsr_rsp_t;

endpackage

>>> hw/rtl/fqsr_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FIFO queue with search and removal: entry store
// Simple dual-port memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module fqsr_store
    import fqsr_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEFAULT,
    parameter int ITEM_WIDTH = ITEM_WIDTH_DEFAULT,
    localparam int IDX_W     = $clog2(DEPTH)
)
(
    input  logic                  clk,
    input  logic                  wr_en,
    input  logic [IDX_W-1:0]      wr_addr,
    input  logic [ITEM_WIDTH-1:0] wr_data,
    input  logic                  rd_en,
    input  logic [IDX_W-1:0]      rd_addr,
    output logic [ITEM_WIDTH-1:0] rd_data
);

    logic [ITEM_WIDTH-1:0] mem [DEPTH];
    logic [ITEM_WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hw/rtl/fqsr_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FIFO queue with search and removal: sequencer
// Runs each operation over the entry store, scans with one comparator, shifts
// entries one per cycle on removal, and holds the response register.
// ----------------------------------------------------------------------------
module fqsr_ctrl
    import fqsr_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEFAULT,
    parameter int ITEM_WIDTH = ITEM_WIDTH_DEFAULT,
    localparam int IDX_W     = $clog2(DEPTH),
    localparam int CNT_W     = $clog2(DEPTH + 1)
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_ready,
    input  fqsr_req_t             req,
    output logic                  rsp_valid,
    input  logic                  rsp_ready,
    output fqsr_rsp_t             rsp,
    output logic                  mem_wr_en,
    output logic [IDX_W-1:0]      mem_wr_addr,
    output logic [ITEM_WIDTH-1:0] mem_wr_data,
    output logic                  mem_rd_en,
    output logic [IDX_W-1:0]      mem_rd_addr,
    input  logic [ITEM_WIDTH-1:0] mem_rd_data
);

    localparam int HW = (ITEM_WIDTH < ITEM_VALUE_W) ? ITEM_WIDTH : ITEM_VALUE_W;
    localparam int OW = (ITEM_WIDTH < ITEM_OUT_W) ? ITEM_WIDTH : ITEM_OUT_W;
    localparam int PW = (CNT_W < POSITION_W) ? CNT_W : POSITION_W;
    localparam int KW = (CNT_W < COUNT_W) ? CNT_W : COUNT_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PUSH,
        S_POP,
        S_POP_WAIT,
        S_SCAN,
        S_SHIFT,
        S_RESP
    } state_t;

    state_t                state_reg,     state_next;
    op_t                   op_reg,        op_next;
    logic [ITEM_WIDTH-1:0] handle_reg,    handle_next;
    logic [CNT_W-1:0]      count_reg,     count_next;
    logic [IDX_W-1:0]      head_reg,      head_next;
    logic [CNT_W-1:0]      rd_idx_reg,    rd_idx_next;
    logic [CNT_W-1:0]      cmp_idx_reg,   cmp_idx_next;
    logic                  cmp_valid_reg, cmp_valid_next;
    logic [CNT_W-1:0]      wr_idx_reg,    wr_idx_next;
    logic                  wr_pend_reg,   wr_pend_next;
    logic [STATUS_W-1:0]   res_status_reg, res_status_next;
    logic [ITEM_OUT_W-1:0] res_item_reg,  res_item_next;
    logic [CNT_W-1:0]      res_pos_reg,   res_pos_next;
    logic                  rsp_valid_reg, rsp_valid_next;
    fqsr_rsp_t             rsp_reg,       rsp_next;
    logic [ITEM_WIDTH-1:0] req_handle;
    logic [ITEM_OUT_W-1:0] popped_item;
    fqsr_rsp_t             rsp_fmt;

    function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] head,
                                                 input logic [CNT_W-1:0] pos);
        logic [CNT_W:0] sum;
        sum = {1'b0, pos} + (CNT_W + 1)'(head);
        if (sum >= (CNT_W + 1)'(DEPTH))
        begin
            sum = sum - (CNT_W + 1)'(DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

    always_comb
    begin
        req_handle = '0;
        req_handle[HW-1:0] = req.item_value[HW-1:0];
        popped_item = '0;
        popped_item[OW-1:0] = mem_rd_data[OW-1:0];
        rsp_fmt = '0;
        rsp_fmt.status = res_status_reg;
        rsp_fmt.item_out = res_item_reg;
        rsp_fmt.position[PW-1:0] = res_pos_reg[PW-1:0];
        rsp_fmt.count[KW-1:0] = count_reg[KW-1:0];
    end

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        handle_next     = handle_reg;
        count_next      = count_reg;
        head_next       = head_reg;
        rd_idx_next     = rd_idx_reg;
        cmp_idx_next    = cmp_idx_reg;
        cmp_valid_next  = cmp_valid_reg;
        wr_idx_next     = wr_idx_reg;
        wr_pend_next    = wr_pend_reg;
        res_status_next = res_status_reg;
        res_item_next   = res_item_reg;
        res_pos_next    = res_pos_reg;
        rsp_valid_next  = rsp_valid_reg;
        rsp_next        = rsp_reg;
        mem_wr_en       = 1'b0;
        mem_wr_addr     = slot_of(head_reg, count_reg);
        mem_wr_data     = handle_reg;
        mem_rd_en       = 1'b0;
        mem_rd_addr     = head_reg;

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    op_next         = op_t'(req.opcode);
                    handle_next     = req_handle;
                    res_status_next = STATUS_OK;
                    res_item_next   = '0;
                    res_pos_next    = '0;
                    rd_idx_next     = '0;
                    cmp_valid_next  = 1'b0;
                    unique case (op_t'(req.opcode))
                        OP_PUSH:   state_next = S_PUSH;
                        OP_POP:    state_next = S_POP;
                        OP_FIND:   state_next = S_SCAN;
                        OP_REMOVE: state_next = S_SCAN;
                    endcase
                end
            end
            S_PUSH:
            begin
                if (count_reg == CNT_W'(DEPTH))
                begin
                    res_status_next = STATUS_FULL;
                end
                else
                begin
                    mem_wr_en  = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                end
                state_next = S_RESP;
            end
            S_POP:
            begin
                if (count_reg == '0)
                begin
                    res_status_next = STATUS_MISS;
                    state_next      = S_RESP;
                end
                else
                begin
                    mem_rd_en  = 1'b1;
                    state_next = S_POP_WAIT;
                end
            end
            S_POP_WAIT:
            begin
                res_item_next = popped_item;
                head_next     = slot_of(head_reg, CNT_W'(1));
                count_next    = count_reg - CNT_W'(1);
                state_next    = S_RESP;
            end
            S_SCAN:
            begin
                if (cmp_valid_reg && (mem_rd_data == handle_reg))
                begin
                    res_pos_next = cmp_idx_reg;
                    if (op_reg == OP_REMOVE)
                    begin
                        rd_idx_next  = cmp_idx_reg + CNT_W'(1);
                        wr_pend_next = 1'b0;
                        state_next   = S_SHIFT;
                    end
                    else
                    begin
                        state_next = S_RESP;
                    end
                end
                else if (rd_idx_reg < count_reg)
                begin
                    mem_rd_en      = 1'b1;
                    mem_rd_addr    = slot_of(head_reg, rd_idx_reg);
                    cmp_idx_next   = rd_idx_reg;
                    cmp_valid_next = 1'b1;
                    rd_idx_next    = rd_idx_reg + CNT_W'(1);
                end
                else
                begin
                    res_status_next = STATUS_MISS;
                    res_pos_next    = '0;
                    state_next      = S_RESP;
                end
            end
            S_SHIFT:
            begin
                if (wr_pend_reg)
                begin
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = slot_of(head_reg, wr_idx_reg);
                    mem_wr_data = mem_rd_data;
                end
                if (rd_idx_reg < count_reg)
                begin
                    mem_rd_en    = 1'b1;
                    mem_rd_addr  = slot_of(head_reg, rd_idx_reg);
                    wr_idx_next  = rd_idx_reg - CNT_W'(1);
                    wr_pend_next = 1'b1;
                    rd_idx_next  = rd_idx_reg + CNT_W'(1);
                end
                else
                begin
                    wr_pend_next = 1'b0;
                    if (!wr_pend_reg)
                    begin
                        count_next = count_reg - CNT_W'(1);
                        state_next = S_RESP;
                    end
                end
            end
            S_RESP:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_next       = rsp_fmt;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            head_reg      <= '0;
            cmp_valid_reg <= 1'b0;
            wr_pend_reg   <= 1'b0;
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            head_reg      <= head_next;
            cmp_valid_reg <= cmp_valid_next;
            wr_pend_reg   <= wr_pend_next;
            rsp_valid_reg <= rsp_valid_next;
            rsp_reg       <= rsp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        handle_reg     <= handle_next;
        rd_idx_reg     <= rd_idx_next;
        cmp_idx_reg    <= cmp_idx_next;
        wr_idx_reg     <= wr_idx_next;
        res_status_reg <= res_status_next;
        res_item_reg   <= res_item_next;
        res_pos_reg    <= res_pos_next;
    end

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

>>> hw/rtl/fifo_queue_with_search_remove.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FIFO queue with search and removal
// Ordered queue of handles with push, pop, find and remove by value.
// ----------------------------------------------------------------------------
//  Channel   Handshake                 Payload
//  request   req_valid / req_ready     req: opcode, item_value
//  response  rsp_valid / rsp_ready     rsp: status, item_out, position, count
//
// Push writes the tail slot and pop reads the head slot. Find and remove take
// time that grows with the entry count, since one memory read port feeds
// one comparator and then the shift, one entry per cycle.
// Reset clears the state, count, head pointer and response register; the store needs no clearing.
// A new request is taken while the previous response still waits.
// ----------------------------------------------------------------------------
module fifo_queue_with_search_remove
    import fqsr_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEFAULT,
    parameter int ITEM_WIDTH = ITEM_WIDTH_DEFAULT
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    input  fqsr_req_t req,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    output fqsr_rsp_t rsp
);

    localparam int IDX_W = $clog2(DEPTH);

    logic                  mem_wr_en;
    logic [IDX_W-1:0]      mem_wr_addr;
    logic [ITEM_WIDTH-1:0] mem_wr_data;
    logic                  mem_rd_en;
    logic [IDX_W-1:0]      mem_rd_addr;
    logic [ITEM_WIDTH-1:0] mem_rd_data;

    fqsr_ctrl #(
        .DEPTH      (DEPTH),
        .ITEM_WIDTH (ITEM_WIDTH)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req         (req),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .rsp         (rsp),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data)
    );

    fqsr_store #(
        .DEPTH      (DEPTH),
        .ITEM_WIDTH (ITEM_WIDTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

endmodule
